[hw/rtl/cursor_linked_list_engine_macros.svh]
// cursor_linked_list_engine_macros.svh: assertion macros for the list engine
// used by clle_back; expects clk_i and rst_ni in the including module
`ifndef CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define CLLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define CLLE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define CLLE_ASSERT(lbl, prop, msg)

`define CLLE_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/clle_pkg.sv]
// clle_pkg: types, codes and defaults shared by the list engine modules
// no dependencies
package clle_pkg;

  localparam int unsigned NODES_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned CMD_DEPTH      = 2;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  position;
    logic [31:0] item_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_out;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  position;
    logic [31:0] data;
  } cmd_t;

endpackage

[hw/rtl/clle_front.sv]
// clle_front: request intake, decode into commands and a short command queue
// depends on clle_pkg
module clle_front import clle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_take_i
);

  localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t            queue_q [CMD_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;
  cmd_t            cmd_new;
  logic            do_push, do_pop;

  always_comb begin
    cmd_new.position = in_item_i.position;
    cmd_new.data     = in_item_i.item_in;
    unique case (in_item_i.kind)
      KIND_INSERT: cmd_new.op = OP_INSERT;
      KIND_APPEND: cmd_new.op = OP_APPEND;
      KIND_DELETE: cmd_new.op = OP_DELETE;
      KIND_READ:   cmd_new.op = OP_READ;
      default:     cmd_new.op = OP_READ;
    endcase
  end

  assign full        = (count_q == CW'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wptr_q] <= cmd_new;
    end
  end

endmodule

[hw/rtl/clle_back.sv]
// clle_back: command execution over the node pool, link and payload memories
// depends on clle_pkg and cursor_linked_list_engine_macros.svh
`include "cursor_linked_list_engine_macros.svh"

module clle_back import clle_pkg::*; #(
  parameter int unsigned NODES      = NODES_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_take_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int unsigned IW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW   = $clog2(NODES + 1);
  localparam int unsigned CMPW = (LW > 5) ? LW : 5;
  localparam logic [LW-1:0] NULL_IDX = LW'(NODES);
  localparam logic [LW-1:0] LAST_CNT = LW'(NODES - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DISP = 9'b000000010,
    S_FREE = 9'b000000100,
    S_STEP = 9'b000001000,
    S_WR1  = 9'b000010000,
    S_WR2  = 9'b000100000,
    S_DEL  = 9'b001000000,
    S_RD   = 9'b010000000,
    S_RESP = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [LW-1:0]   tgt_q, tgt_d;
  logic [LW-1:0]   cnt_q, cnt_d;
  logic [LW-1:0]   cur_q, cur_d;
  logic [LW-1:0]   prev_q, prev_d;
  logic [LW-1:0]   node_q, node_d;
  logic [LW-1:0]   head_q, head_d;
  logic [LW-1:0]   free_q, free_d;
  logic [LW-1:0]   len_q, len_d;
  out_item_t       pend_q, pend_d;
  out_item_t       res_q, res_d;
  logic            res_vld_q, res_vld_d;

  // link memory with per-entry valid bits standing for the reset chain
  logic [LW-1:0]   link_mem [NODES];
  logic [NODES-1:0] link_vld_q;
  logic [LW-1:0]   lrd_raw_q;
  logic [IW-1:0]   lrd_addr_q;
  logic            lrd_vld_q;
  logic [LW-1:0]   link_rd;

  logic [DATA_WIDTH-1:0] pay_mem [NODES];
  logic [DATA_WIDTH-1:0] prd_q;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            lwr_en;
  logic [IW-1:0]   lwr_addr;
  logic [LW-1:0]   lwr_data;
  logic            pwr_en;

  logic            out_ready;
  logic            rd_last;
  logic [63:0]     in_ext;
  logic [63:0]     out_ext;

  assign in_ext  = {32'b0, cmd_q.data};
  assign out_ext = 64'(prd_q);
  assign link_rd = lrd_vld_q ? lrd_raw_q :
                   ((lrd_addr_q == '0) ? NULL_IDX : LW'(lrd_addr_q) - 1'b1);

  assign out_ready  = !res_vld_q || pop;
  assign empty      = !res_vld_q;
  assign out_item_o = res_q;
  assign rd_last    = (link_rd >= NULL_IDX) || (cnt_q == LAST_CNT);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    tgt_d      = tgt_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    node_d     = node_q;
    head_d     = head_q;
    free_d     = free_q;
    len_d      = len_q;
    pend_d     = pend_q;
    res_d      = res_q;
    res_vld_d  = res_vld_q && !pop;
    cmd_take_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    lwr_en     = 1'b0;
    lwr_addr   = '0;
    lwr_data   = '0;
    pwr_en     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          cmd_d      = cmd_i;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        pend_d = '{status: ST_OK, item_out: 32'b0, last: 1'b1};
        unique case (cmd_q.op)
          OP_INSERT, OP_APPEND: begin
            tgt_d  = (cmd_q.op == OP_APPEND) ? len_q : LW'(cmd_q.position);
            cnt_d  = '0;
            cur_d  = head_q;
            prev_d = NULL_IDX;
            node_d = free_q;
            if (cmd_q.op == OP_INSERT && CMPW'(cmd_q.position) > CMPW'(len_q)) begin
              pend_d.status = ST_PAST_END;
              state_d       = S_RESP;
            end else if (free_q >= NULL_IDX) begin
              pend_d.status = ST_FULL;
              state_d       = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = free_q[IW-1:0];
              state_d = S_FREE;
            end
          end
          OP_DELETE: begin
            if (head_q >= NULL_IDX) begin
              pend_d.status = ST_EMPTY;
              state_d       = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q[IW-1:0];
              state_d = S_DEL;
            end
          end
          OP_READ: begin
            cnt_d = '0;
            if (head_q >= NULL_IDX) begin
              pend_d.status = ST_EMPTY;
              state_d       = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q[IW-1:0];
              state_d = S_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FREE: begin
        free_d = link_rd;
        if (tgt_q == '0) begin
          state_d = S_WR1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_q[IW-1:0];
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        prev_d = cur_q;
        cur_d  = link_rd;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == tgt_q) begin
          state_d = S_WR1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = link_rd[IW-1:0];
        end
      end
      S_WR1: begin
        lwr_en   = 1'b1;
        lwr_addr = node_q[IW-1:0];
        lwr_data = (cur_q < NULL_IDX) ? cur_q : NULL_IDX;
        pwr_en   = 1'b1;
        state_d  = S_WR2;
      end
      S_WR2: begin
        if (prev_q < NULL_IDX) begin
          lwr_en   = 1'b1;
          lwr_addr = prev_q[IW-1:0];
          lwr_data = node_q;
        end else begin
          head_d = node_q;
        end
        len_d   = len_q + 1'b1;
        state_d = S_RESP;
      end
      S_DEL: begin
        head_d   = link_rd;
        lwr_en   = 1'b1;
        lwr_addr = head_q[IW-1:0];
        lwr_data = free_q;
        free_d   = head_q;
        len_d    = len_q - 1'b1;
        state_d  = S_RESP;
      end
      S_RD: begin
        if (out_ready) begin
          res_vld_d      = 1'b1;
          res_d.status   = ST_OK;
          res_d.item_out = out_ext[31:0];
          res_d.last     = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = link_rd[IW-1:0];
          end
        end
      end
      S_RESP: begin
        if (out_ready) begin
          res_vld_d = 1'b1;
          res_d     = pend_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= NULL_IDX;
      free_q     <= LW'(NODES - 1);
      len_q      <= '0;
      res_vld_q  <= 1'b0;
      link_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      free_q    <= free_d;
      len_q     <= len_d;
      res_vld_q <= res_vld_d;
      if (lwr_en) begin
        link_vld_q[lwr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    tgt_q  <= tgt_d;
    cnt_q  <= cnt_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    node_q <= node_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
    if (rd_en) begin
      lrd_raw_q  <= link_mem[rd_addr];
      lrd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrd_vld_q <= 1'b0;
    end else if (rd_en) begin
      lrd_vld_q <= link_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      pay_mem[node_q[IW-1:0]] <= in_ext[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      prd_q <= pay_mem[rd_addr];
    end
  end

  `CLLE_ASSERT(a_head_len, (head_q >= NULL_IDX) == (len_q == '0), "head and length disagree")
  `CLLE_ASSERT(a_len_bound, len_q <= LW'(NODES), "list longer than the pool")
  `CLLE_ASSERT_IMPLY(a_step_bound, state_q == S_STEP, cnt_q < tgt_q, "walk ran past target")
  `CLLE_ASSERT_IMPLY(a_more_follow, res_vld_q && !res_q.last, state_q == S_RD,
                     "non-final result without a read in progress")

endmodule

[hw/rtl/cursor_linked_list_engine.sv]
// cursor_linked_list_engine: singly linked list in a fixed node pool
// Requests enter through a queue-style port: a request is taken at a clock edge
// with push high and full low. Kinds: insert at position, append, delete first,
// read all. Results leave through a queue-style port: the oldest result sits on
// out_item_o while empty is low and is taken at an edge with pop high.
// Insert, append and delete give one result; read all gives one per element,
// with last set on the final one (one result, status empty, on an empty list).
// Each request is decoded after it is taken; a refused or empty-list request
// goes straight to its result. Delete reads the head link and returns the node
// to the free list; insert and append take the free head, walk the links to the
// position, then write the new node's link and payload and the previous link or
// the head. Read all shows one element per cycle while the receiver keeps up.
// Requests run one at a time; the walk takes one read of the link memory per link.
// A two-deep request queue lets new requests in while a result waits; a stalled
// receiver holds the execution unit, and full rises once the queue fills.
// Reset (asynchronous, active low) empties the list and chains every node into
// the free list at once; no sweep of the memories is needed.
// depends on clle_pkg, clle_front and clle_back
module cursor_linked_list_engine import clle_pkg::*; #(
  parameter int unsigned NODES      = NODES_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  clle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  clle_back #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule
